### rtl/core/lz_token_decompressor_defines.svh
// ----------------------------------------------------------------------------
// LZ token decompressor assertion macros
// Shared property shapes for the checker of the decompressor.
// ----------------------------------------------------------------------------
`ifndef LZ_TOKEN_DECOMPRESSOR_DEFINES_SVH
`define LZ_TOKEN_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZTD_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lz_token_decompressor: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZTD_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lz_token_decompressor: property failed");

`endif

### rtl/core/lztd_pkg.sv
// ----------------------------------------------------------------------------
// LZ token decompressor package
// Types, constants and codes shared by the decompressor modules.
// ----------------------------------------------------------------------------
package lztd_pkg;

  localparam int unsigned WindowDepth = 16384;
  localparam int unsigned AddrW       = $clog2(WindowDepth);
  localparam int unsigned ProdW       = $clog2(WindowDepth + 1);
  localparam int unsigned OffW        = 14;
  localparam int unsigned OutLanes    = 4;
  localparam int unsigned MaxLanes    = 4;
  localparam int unsigned LaneCnt     = (OutLanes > MaxLanes) ? MaxLanes :
                                        ((OutLanes < 1) ? 1 : OutLanes);
  localparam int unsigned LaneIdxW    = $clog2(MaxLanes);
  localparam int unsigned FillW       = $clog2(MaxLanes + 1);
  localparam int unsigned RemainW     = 8;

  localparam logic [7:0] LitTokMask  = 8'hC0;
  localparam logic [5:0] LowMask     = 6'h3F;
  localparam logic [7:0] MatchBias   = 8'd4;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_OFFSET = 2'd1,
    ERR_TRUNC  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    PH_TOKEN = 2'd0,
    PH_LIT   = 2'd1,
    PH_OFF1  = 2'd2,
    PH_OFF2  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_WRITE,
    ST_EMIT,
    ST_FINISH,
    ST_TRUNC
  } state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last_of_run;
    logic [1:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic             wr;
    logic [7:0]       wdata;
    logic             rd;
    logic             load;
    logic [AddrW-1:0] off;
  } hist_cmd_t;

endpackage

### rtl/core/lz_token_decompressor.sv
// ----------------------------------------------------------------------------
// LZ token decompressor
// Rebuilds a byte stream from literal runs and history matches.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------
//   in      | input     | in_valid_i/in_stall_o | in_item_t
//   out     | output    | out_valid_o/out_stall_i | out_item_t
//
// A token byte or a first offset byte goes through the decode and finish
// states, a literal through decode, emit and finish. A match alternates read
// and write states for each byte: each byte needs a history read and a write
// through the single memory port pair. A truncation result takes an extra
// state. Reset needs no clearing pass. Output stalls hold the sequencer in
// its emit states until the result register drains.
// ----------------------------------------------------------------------------
module lz_token_decompressor
  import lztd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  hist_cmd_t  hist_cmd;
  logic [7:0] hist_rdata;

  lztd_sequencer u_sequencer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .hist_cmd_o   (hist_cmd),
    .hist_rdata_i (hist_rdata)
  );

  lztd_history u_history (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (hist_cmd),
    .rdata_o (hist_rdata)
  );

endmodule

### rtl/core/lztd_history.sv
// ----------------------------------------------------------------------------
// LZ token decompressor history store
// Window of recent output bytes with its write pointer and copy read index.
// ----------------------------------------------------------------------------
module lztd_history
  import lztd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hist_cmd_t  cmd_i,
  output logic [7:0] rdata_o
);

  logic [7:0]       mem [WindowDepth];
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [7:0]       rdata_q;

  always_comb begin
    wp_d  = cmd_i.wr ? wp_q + AddrW'(1) : wp_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = wp_q - cmd_i.off;
    end else if (cmd_i.rd) begin
      idx_d = idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      idx_q <= '0;
    end else begin
      wp_q  <= wp_d;
      idx_q <= idx_d;
    end
  end

  // A read never targets the entry written in the same cycle: the sequencer
  // separates read and write into different states.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wp_q] <= cmd_i.wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/lztd_sequencer.sv
// ----------------------------------------------------------------------------
// LZ token decompressor sequencer
// Parses tokens, steps match copies through the history and packs results.
// ----------------------------------------------------------------------------
module lztd_sequencer
  import lztd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  output hist_cmd_t  hist_cmd_o,
  input  logic [7:0] hist_rdata_i
);

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [6:0]           lit_left_q, lit_left_d;
  logic [7:0]           match_len_q, match_len_d;
  logic [5:0]           off_high_q, off_high_d;
  logic [ProdW-1:0]     produced_q, produced_d;
  logic [7:0]           byte_q, byte_d;
  logic                 eos_q, eos_d;
  logic                 trunc_q, trunc_d;
  logic [RemainW-1:0]   remain_q, remain_d;
  logic [7:0]           lanes_q [MaxLanes];
  logic [7:0]           lanes_d [MaxLanes];
  logic [FillW-1:0]     fill_q, fill_d;
  err_e                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  // Decode helpers.
  logic                 is_lit_tok;
  logic                 tok_done;
  logic [OffW-1:0]      off_val;
  logic                 off_bad;
  logic [ProdW-1:0]     prod_inc;
  logic                 out_free;
  logic                 out_load;
  logic                 lane_full;
  logic [7:0]           lane_out [MaxLanes];

  assign is_lit_tok = (byte_q & LitTokMask) == LitTokMask;
  assign off_val    = (phase_q == PH_OFF2) ? {off_high_q, byte_q} : OffW'(byte_q);
  assign off_bad    = (off_val == '0) || (ProdW'(off_val) > produced_q);
  assign prod_inc   = (produced_q < ProdW'(WindowDepth)) ? produced_q + ProdW'(1)
                                                          : produced_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign lane_full  = (fill_q + FillW'(1)) == FillW'(LaneCnt);
  // A match starts once the offset is complete; a first offset byte of two
  // only records the high bits.
  assign tok_done   = (phase_q == PH_OFF2) || ((phase_q == PH_OFF1) && !is_lit_tok);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        unique case (phase_q)
          PH_LIT:   state_d = ST_EMIT;
          PH_TOKEN: state_d = ST_FINISH;
          default:  begin
            if (!tok_done) begin
              state_d = ST_FINISH;
            end else if (off_bad) begin
              state_d = ST_EMIT;
            end else begin
              state_d = ST_READ;
            end
          end
        endcase
      end
      ST_READ:   state_d = ST_WRITE;
      ST_WRITE:  state_d = (lane_full || remain_q == RemainW'(1)) ? ST_EMIT : ST_READ;
      ST_EMIT:   begin
        if (out_free) begin
          state_d = (remain_q != '0) ? ST_READ : ST_FINISH;
        end
      end
      ST_FINISH: state_d = trunc_q ? ST_TRUNC : ST_IDLE;
      ST_TRUNC:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs and history commands.
  always_comb begin
    hist_cmd_o       = '0;
    hist_cmd_o.off   = off_val[AddrW-1:0];
    hist_cmd_o.wdata = (state_q == ST_WRITE) ? hist_rdata_i : byte_q;
    out_load         = 1'b0;
    unique case (state_q)
      ST_DECODE: begin
        hist_cmd_o.wr   = (phase_q == PH_LIT);
        hist_cmd_o.load = (phase_q != PH_LIT) && (phase_q != PH_TOKEN) && tok_done && !off_bad;
      end
      ST_READ:   hist_cmd_o.rd = 1'b1;
      ST_WRITE:  hist_cmd_o.wr = 1'b1;
      ST_EMIT,
      ST_TRUNC:  out_load = out_free;
      default:   ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MaxLanes; i++) begin
      lane_out[i] = (FillW'(i) < fill_q) ? lanes_q[i] : 8'd0;
    end
  end

  // Datapath registers.
  always_comb begin
    phase_d     = phase_q;
    lit_left_d  = lit_left_q;
    match_len_d = match_len_q;
    off_high_d  = off_high_q;
    produced_d  = produced_q;
    byte_d      = byte_q;
    eos_d       = eos_q;
    trunc_d     = trunc_q;
    remain_d    = remain_q;
    lanes_d     = lanes_q;
    fill_d      = fill_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d = in_data_i.in_byte;
          eos_d  = in_data_i.end_of_stream;
        end
      end
      ST_DECODE: begin
        fill_d   = '0;
        err_d    = ERR_NONE;
        remain_d = '0;
        case (phase_q)
          PH_TOKEN: begin
            if (is_lit_tok) begin
              lit_left_d = 7'({1'b0, byte_q[5:0]}) + 7'd1;
              phase_d    = PH_LIT;
            end else begin
              match_len_d = byte_q;
              phase_d     = PH_OFF1;
            end
          end
          PH_LIT: begin
            lanes_d[0] = byte_q;
            fill_d     = FillW'(1);
            produced_d = prod_inc;
            lit_left_d = (lit_left_q != '0) ? lit_left_q - 7'd1 : lit_left_q;
            phase_d    = (lit_left_d == '0) ? PH_TOKEN : PH_LIT;
          end
          default: begin
            if (!tok_done) begin
              off_high_d = byte_q[5:0] & LowMask;
              phase_d    = PH_OFF2;
            end else begin
              phase_d = PH_TOKEN;
              if (off_bad) begin
                err_d = ERR_OFFSET;
              end else begin
                remain_d = match_len_q + MatchBias;
              end
            end
          end
        endcase
        trunc_d = eos_q && (phase_d != PH_TOKEN);
      end
      ST_WRITE: begin
        lanes_d[fill_q[LaneIdxW-1:0]] = hist_rdata_i;
        fill_d     = fill_q + FillW'(1);
        remain_d   = remain_q - RemainW'(1);
        produced_d = prod_inc;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d           = 1'b1;
          out_d.out_byte0       = lane_out[0];
          out_d.out_byte1       = lane_out[1];
          out_d.out_byte2       = lane_out[2];
          out_d.out_byte3       = lane_out[3];
          out_d.byte_count      = 3'(fill_q);
          out_d.last_of_run     = (remain_q == '0) && !trunc_q;
          out_d.error_code      = err_q;
          fill_d                = '0;
        end
      end
      ST_FINISH: begin
        if (!trunc_q && eos_q) begin
          phase_d    = PH_TOKEN;
          lit_left_d = '0;
          produced_d = '0;
        end
      end
      ST_TRUNC: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last_of_run = 1'b1;
          out_d.error_code  = ERR_TRUNC;
          // Truncation is only flagged on the final byte of a stream.
          phase_d     = PH_TOKEN;
          lit_left_d  = '0;
          produced_d  = '0;
          trunc_d     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_TOKEN;
      lit_left_q  <= '0;
      match_len_q <= '0;
      off_high_q  <= '0;
      produced_q  <= '0;
      eos_q       <= 1'b0;
      trunc_q     <= 1'b0;
      remain_q    <= '0;
      fill_q      <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      lit_left_q  <= lit_left_d;
      match_len_q <= match_len_d;
      off_high_q  <= off_high_d;
      produced_q  <= produced_d;
      eos_q       <= eos_d;
      trunc_q     <= trunc_d;
      remain_q    <= remain_d;
      fill_q      <= fill_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    lanes_q <= lanes_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/lztd_checker.sv
// ----------------------------------------------------------------------------
// LZ token decompressor checker
// Port-level properties of the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`include "lz_token_decompressor_defines.svh"

module lztd_checker
  import lztd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result stays offered and unchanged.
  `LZTD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Each accepted transaction keeps the input side busy while it is decoded.
  `LZTD_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Error results carry no bytes and close the run of their input byte.
  `LZTD_ASSERT_IMP(a_err_shape, clk_i, rst_ni, out_valid_o && (out_data_o.error_code != ERR_NONE), (out_data_o.byte_count == 3'd0) && out_data_o.last_of_run && (out_data_o.error_code != 2'd3))

  // A data result carries between one and four bytes.
  `LZTD_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_o && (out_data_o.error_code == ERR_NONE), (out_data_o.byte_count != 3'd0) && (out_data_o.byte_count <= 3'd4))

  // The top lane reads as zero when the byte count is below four.
  `LZTD_ASSERT_IMP(a_unused_lane, clk_i, rst_ni, out_valid_o && (out_data_o.byte_count < 3'd4), out_data_o.out_byte3 == 8'd0)

endmodule

bind lz_token_decompressor lztd_checker u_lztd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
